>>> rtl/great_circle_distance_defines.svh
// assertion macros for the great-circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS

// condition in this cycle implies the expression in the next cycle
`define GCD_ASSERT_NEXT(lbl, ck, rn, cond, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error("great-circle distance pipeline check failed");

// condition implies the expression in the same cycle
`define GCD_ASSERT_IMPL(lbl, ck, rn, cond, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error("great-circle distance pipeline check failed");

`else

`define GCD_ASSERT_NEXT(lbl, ck, rn, cond, expr)
`define GCD_ASSERT_IMPL(lbl, ck, rn, cond, expr)

`endif

`endif

>>> rtl/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

    // latency of one sine/cosine unit and of one degree-to-angle unit
    localparam int SC_LAT  = 15;
    localparam int ANG_LAT = 3;

    // sine and cosine as magnitude and sign, q32
    typedef struct packed {
        logic [32:0] sin_mag;
        logic        sin_neg;
        logic [32:0] cos_mag;
        logic        cos_neg;
    } trig_t;

    // working value and partial root of the square-root chain
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sqrt_t;

    // partial arcsine, compare target and clamp flag
    typedef struct packed {
        logic [29:0] th;
        logic [32:0] target;
        logic        sat;
    } asin_t;

endpackage

>>> rtl/gcd_angle.sv
`timescale 1ns / 1ps

module gcd_angle #(
    parameter int WIDTH     = 25,
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] raw,
    output logic [31:0]      angle
);
    import gcd_pkg::*;

    localparam int SH = 32 - FRAC_BITS;
    // exact reciprocals of 360 for 25-bit and 33-bit dividends
    localparam logic [25:0] M1 = 26'(((64'd1 << 34) + 64'd359) / 64'd360);
    localparam logic [33:0] M2 = 34'(((64'd1 << 42) + 64'd359) / 64'd360);

    logic             neg;
    logic [WIDTH-1:0] negated;
    logic [24:0]      mag;
    logic [50:0]      prod1_reg;
    logic [24:0]      mag_reg;
    logic             neg1_reg;
    logic [16:0]      qm;
    logic [8:0]       rm;
    logic [32:0]      y;
    logic [66:0]      prod2_reg;
    logic [16:0]      qm_reg;
    logic             neg2_reg;
    logic [31:0]      a_val;
    logic [31:0]      angle_reg;

    // sign and magnitude of the degree value
    assign neg     = raw[WIDTH-1];
    assign negated = (~raw) + WIDTH'(1);
    assign mag     = 25'(neg ? negated : raw);

    // split magnitude into whole turns of 360 and a remainder
    assign qm = prod1_reg[50:34];
    assign rm = 9'(mag_reg - 25'(qm) * 25'd360);
    assign y  = (33'(rm) << SH) + 33'd180;

    // rounded binary angle
    assign a_val = (32'(qm_reg) << SH) + 32'(prod2_reg >> 42);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= 51'(mag) * 51'(M1);
            mag_reg   <= mag;
            neg1_reg  <= neg;
            prod2_reg <= 67'(y) * 67'(M2);
            qm_reg    <= qm;
            neg2_reg  <= neg1_reg;
            angle_reg <= neg2_reg ? (32'd0 - a_val) : a_val;
        end
    end

    assign angle = angle_reg;

endmodule

>>> rtl/gcd_sincos.sv
`timescale 1ns / 1ps

module gcd_sincos
(
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    angle,
    output gcd_pkg::trig_t trig
);
    import gcd_pkg::*;

    localparam int NSTEP = 6;
    localparam int SIN_K [NSTEP-1] = '{110, 72, 42, 20, 6};
    localparam int COS_K [NSTEP]   = '{132, 90, 56, 30, 12, 2};
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [33:0] PI_Q32  = 34'h3_243F_6A89;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] x2;
        logic [1:0]  quad;
        logic        swap;
    } carry_t;

    logic [29:0] r_low;
    logic        swap_in;
    logic [29:0] r_red;
    logic [63:0] rpi_reg;
    logic [1:0]  quad1_reg;
    logic        swap1_reg;
    logic [31:0] x_val;
    logic [31:0] x_reg;
    logic [63:0] xx_reg;
    logic [1:0]  quad2_reg;
    logic        swap2_reg;
    carry_t      carry_w [NSTEP+1];
    logic [32:0] ts_w [NSTEP+1];
    logic [32:0] tc_w [NSTEP+1];
    logic [32:0] s_val;
    logic [32:0] c_val;
    trig_t       trig_next;
    trig_t       trig_reg;

    // fold into the first octant
    assign r_low   = angle[29:0];
    assign swap_in = r_low > 30'h2000_0000;
    assign r_red   = swap_in ? 30'(31'h4000_0000 - {1'b0, r_low}) : r_low;
    assign x_val   = rpi_reg[62:31];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rpi_reg   <= 64'(r_red) * 64'(PI_Q32);
            quad1_reg <= angle[31:30];
            swap1_reg <= swap_in;
            x_reg     <= x_val;
            xx_reg    <= 64'(x_val) * 64'(x_val);
            quad2_reg <= quad1_reg;
            swap2_reg <= swap1_reg;
        end
    end

    assign carry_w[0] = '{x: x_reg, x2: xx_reg[63:32], quad: quad2_reg, swap: swap2_reg};
    assign ts_w[0]    = ONE_Q32;
    assign tc_w[0]    = ONE_Q32;

    // horner steps, two stages each: product, then divide by reciprocal
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        localparam int KC = COS_K[j];
        localparam int LC = $clog2(KC);
        localparam logic [33:0] MC =
            34'(((64'd1 << (32 + LC)) + 64'(KC) - 64'd1) / 64'(KC));

        logic [63:0] mc_reg;
        logic [65:0] pc_reg;
        carry_t      ca_reg;
        carry_t      cb_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mc_reg <= 64'(carry_w[j].x2) * 64'(tc_w[j]);
                pc_reg <= 66'(mc_reg[63:32]) * 66'(MC);
                ca_reg <= carry_w[j];
                cb_reg <= ca_reg;
            end
        end

        assign tc_w[j+1]    = ONE_Q32 - 33'(pc_reg >> (32 + LC));
        assign carry_w[j+1] = cb_reg;

        if (j < NSTEP - 1)
        begin : g_sin
            localparam int KS = SIN_K[j];
            localparam int LS = $clog2(KS);
            localparam logic [33:0] MS =
                34'(((64'd1 << (32 + LS)) + 64'(KS) - 64'd1) / 64'(KS));

            logic [63:0] ms_reg;
            logic [65:0] ps_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ms_reg <= 64'(carry_w[j].x2) * 64'(ts_w[j]);
                    ps_reg <= 66'(ms_reg[63:32]) * 66'(MS);
                end
            end

            assign ts_w[j+1] = ONE_Q32 - 33'(ps_reg >> (32 + LS));
        end
        else
        begin : g_sin_out
            // sine is x times the series
            logic [63:0] ms_reg;
            logic [31:0] s_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ms_reg <= 64'(carry_w[j].x) * 64'(ts_w[j]);
                    s_reg  <= ms_reg[63:32];
                end
            end

            assign ts_w[j+1] = {1'b0, s_reg};
        end
    end

    // undo the octant fold and apply quadrant signs
    always_comb
    begin
        s_val = carry_w[NSTEP].swap ? tc_w[NSTEP] : ts_w[NSTEP];
        c_val = carry_w[NSTEP].swap ? ts_w[NSTEP] : tc_w[NSTEP];
        trig_next.sin_mag = carry_w[NSTEP].quad[0] ? c_val : s_val;
        trig_next.cos_mag = carry_w[NSTEP].quad[0] ? s_val : c_val;
        trig_next.sin_neg = carry_w[NSTEP].quad[1] && (trig_next.sin_mag != 33'd0);
        trig_next.cos_neg = (carry_w[NSTEP].quad[1] ^ carry_w[NSTEP].quad[0])
                            && (trig_next.cos_mag != 33'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

>>> rtl/gcd_sqrt_cell.sv
`timescale 1ns / 1ps

module gcd_sqrt_cell #(
    parameter int BIT_POS = 62
)
(
    input  logic           clk,
    input  logic           en,
    input  gcd_pkg::sqrt_t din,
    output gcd_pkg::sqrt_t dout
);
    import gcd_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << BIT_POS;

    logic [63:0] trial;
    logic        take;
    sqrt_t       dout_next;
    sqrt_t       dout_reg;

    // one root bit: compare, subtract and shift
    always_comb
    begin
        trial = din.res + BIT;
        take  = din.v >= trial;
        dout_next.v   = take ? (din.v - trial) : din.v;
        dout_next.res = take ? ((din.res >> 1) + BIT) : (din.res >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/gcd_asin_cell.sv
`timescale 1ns / 1ps

module gcd_asin_cell #(
    parameter int BIT_POS = 29
)
(
    input  logic           clk,
    input  logic           en,
    input  gcd_pkg::asin_t din,
    output gcd_pkg::asin_t dout
);
    import gcd_pkg::*;

    localparam logic [29:0] BIT = 30'd1 << BIT_POS;

    logic [31:0] cand;
    trig_t       trig;
    asin_t       dly_reg [SC_LAT];
    logic [29:0] cand_d;
    logic        fits;
    asin_t       dout_next;
    asin_t       dout_reg;

    // sine of the candidate angle
    assign cand = {2'b00, din.th | BIT};

    gcd_sincos u_sincos (
        .clk   (clk),
        .en    (en),
        .angle (cand),
        .trig  (trig)
    );

    // partial result waits alongside the sine unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < SC_LAT; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // keep the bit when its sine stays within the target
    always_comb
    begin
        cand_d    = dly_reg[SC_LAT-1].th | BIT;
        fits      = !trig.sin_neg && (trig.sin_mag <= dly_reg[SC_LAT-1].target);
        dout_next = dly_reg[SC_LAT-1];
        dout_next.th = fits ? cand_d : dly_reg[SC_LAT-1].th;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// channel         direction  handshake                fields
// pair            in         pair_valid / pair_stall   lon_a, lat_a, lon_b, lat_b
// dist            out        dist_valid / dist_stall   distance
// sphere_radius   config     sphere_radius_we          sphere_radius
//
// one point pair per cycle while no result is stalled; the depth is set by the 30 arcsine cells,
// each a 15-stage sine unit plus a compare stage, and the 32 square-root cells
// reset clears the valid bits and loads the earth radius in miles
// a stalled result freezes the whole pipeline and stalls the input side

`include "great_circle_distance_defines.svh"

module great_circle_distance #(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_b,
    input  logic signed [23:0] lat_b,
    output logic               dist_valid,
    input  logic               dist_stall,
    output logic [29:0]        distance,
    input  logic               sphere_radius_we,
    input  logic [27:0]        sphere_radius
);
    import gcd_pkg::*;

    localparam int SQRT_CELLS = 32;
    localparam int ASIN_CELLS = 30;
    localparam int LAT = ANG_LAT + SC_LAT + 3 + SQRT_CELLS + ASIN_CELLS * (SC_LAT + 1) + 2;
    localparam logic [63:0] RAD_RST_FULL =
        ((64'd3958747716 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [27:0] RAD_RST = RAD_RST_FULL[27:0];
    localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;

    logic              advance;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;
    logic              dist_valid_reg;
    logic              dist_valid_next;
    logic [27:0]       radius_reg;
    logic [27:0]       radius_next;
    logic [31:0]       ang_lon_a;
    logic [31:0]       ang_lat_a;
    logic [31:0]       ang_lon_b;
    logic [31:0]       ang_lat_b;
    logic [31:0]       sc_in [4];
    trig_t             trig_w [4];
    logic              neg_lat;
    logic [31:0]       ma;
    logic [31:0]       mb;
    logic [31:0]       sl;
    logic [31:0]       so;
    logic [63:0]       pp_reg;
    logic [63:0]       qp_reg;
    logic [63:0]       h0_reg;
    logic              neg1_reg;
    logic [63:0]       term_reg;
    logic [63:0]       h1_reg;
    logic              neg2_reg;
    logic [63:0]       h_reg;
    logic [63:0]       h_next;
    sqrt_t             sq_w [SQRT_CELLS+1];
    logic [63:0]       root;
    logic              root_sat;
    logic [31:0]       root_clamped;
    asin_t             as_w [ASIN_CELLS+1];
    logic [30:0]       ang_out;
    logic [63:0]       rad_prod_reg;
    logic [31:0]       rad;
    logic [63:0]       dist_prod_reg;
    logic [29:0]       dist_reg;
    logic [29:0]       dist_next;

    function automatic logic [31:0] half_fold(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d > 32'h8000_0000)
        begin
            d = 32'd0 - d;
        end
        return d >> 1;
    endfunction

    // whole pipeline moves unless a finished word is held
    assign advance    = !dist_valid_reg || !dist_stall;
    assign pair_stall = !advance;

    // valid bits, result valid flag and radius register
    always_comb
    begin
        vld_next        = vld_reg;
        dist_valid_next = dist_valid_reg;
        radius_next     = radius_reg;
        if (advance)
        begin
            vld_next        = {vld_reg[LAT-2:0], pair_valid};
            dist_valid_next = vld_reg[LAT-1];
        end
        if (sphere_radius_we)
        begin
            radius_next = sphere_radius;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            dist_valid_reg <= 1'b0;
            radius_reg     <= RAD_RST;
        end
        else
        begin
            vld_reg        <= vld_next;
            dist_valid_reg <= dist_valid_next;
            radius_reg     <= radius_next;
        end
    end

    // degrees to binary angles
    gcd_angle #(.WIDTH(25), .FRAC_BITS(FRAC_BITS)) u_ang_lon_a (
        .clk (clk), .en (advance), .raw (lon_a), .angle (ang_lon_a)
    );
    gcd_angle #(.WIDTH(24), .FRAC_BITS(FRAC_BITS)) u_ang_lat_a (
        .clk (clk), .en (advance), .raw (lat_a), .angle (ang_lat_a)
    );
    gcd_angle #(.WIDTH(25), .FRAC_BITS(FRAC_BITS)) u_ang_lon_b (
        .clk (clk), .en (advance), .raw (lon_b), .angle (ang_lon_b)
    );
    gcd_angle #(.WIDTH(24), .FRAC_BITS(FRAC_BITS)) u_ang_lat_b (
        .clk (clk), .en (advance), .raw (lat_b), .angle (ang_lat_b)
    );

    // latitudes and folded half differences into four sine units
    assign sc_in[0] = ang_lat_a;
    assign sc_in[1] = ang_lat_b;
    assign sc_in[2] = half_fold(ang_lat_a, ang_lat_b);
    assign sc_in[3] = half_fold(ang_lon_a, ang_lon_b);

    for (genvar i = 0; i < 4; i++)
    begin : g_trig
        gcd_sincos u_sincos (
            .clk   (clk),
            .en    (advance),
            .angle (sc_in[i]),
            .trig  (trig_w[i])
        );
    end

    // haversine term
    always_comb
    begin
        ma      = 32'((34'(trig_w[0].cos_mag) + 34'd1) >> 1);
        mb      = 32'((34'(trig_w[1].cos_mag) + 34'd1) >> 1);
        sl      = 32'((34'(trig_w[2].sin_mag) + 34'd1) >> 1);
        so      = 32'((34'(trig_w[3].sin_mag) + 34'd1) >> 1);
        neg_lat = trig_w[0].cos_neg != trig_w[1].cos_neg;
        if (neg2_reg)
        begin
            h_next = (h1_reg > term_reg) ? (h1_reg - term_reg) : 64'd0;
        end
        else
        begin
            h_next = h1_reg + term_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pp_reg   <= 64'(ma) * 64'(mb);
            qp_reg   <= 64'(so) * 64'(so);
            h0_reg   <= 64'(sl) * 64'(sl);
            neg1_reg <= neg_lat;
            term_reg <= 64'(pp_reg[62:31]) * 64'(qp_reg[62:31]);
            h1_reg   <= h0_reg;
            neg2_reg <= neg1_reg;
            h_reg    <= h_next;
        end
    end

    // square root, one bit per cell
    assign sq_w[0] = '{v: h_reg, res: 64'd0};

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        gcd_sqrt_cell #(.BIT_POS(62 - 2 * i)) u_cell (
            .clk  (clk),
            .en   (advance),
            .din  (sq_w[i]),
            .dout (sq_w[i+1])
        );
    end

    // clamp to one and start the arcsine search
    assign root         = sq_w[SQRT_CELLS].res;
    assign root_sat     = root >= 64'h8000_0000;
    assign root_clamped = root_sat ? 32'h8000_0000 : root[31:0];
    assign as_w[0]      = '{th: 30'd0, target: {root_clamped, 1'b0}, sat: root_sat};

    for (genvar i = 0; i < ASIN_CELLS; i++)
    begin : g_asin
        gcd_asin_cell #(.BIT_POS(ASIN_CELLS - 1 - i)) u_cell (
            .clk  (clk),
            .en   (advance),
            .din  (as_w[i]),
            .dout (as_w[i+1])
        );
    end

    // angle to radians, then scale by the radius
    assign ang_out   = as_w[ASIN_CELLS].sat ? 31'h4000_0000 : {1'b0, as_w[ASIN_CELLS].th};
    assign rad       = rad_prod_reg[61:30];
    assign dist_next = 30'((dist_prod_reg + 64'h2000_0000) >> 30);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_prod_reg  <= 64'(ang_out) * 64'(PI_Q30) + 64'h2000_0000;
            dist_prod_reg <= 64'(radius_reg) * 64'(rad);
            dist_reg      <= dist_next;
        end
    end

    assign dist_valid = dist_valid_reg;
    assign distance   = dist_reg;

    // a word leaving the last stage lands in the result register
    `GCD_ASSERT_NEXT(a_result_load, clk, rst_n, advance && vld_reg[LAT-1], dist_valid)
    // a taken word with nothing behind it leaves the output empty
    `GCD_ASSERT_NEXT(a_result_drain, clk, rst_n,
                     dist_valid && !dist_stall && !vld_reg[LAT-1], !dist_valid)
    // a held word freezes the valid chain
    `GCD_ASSERT_NEXT(a_chain_hold, clk, rst_n, !advance, $stable(vld_reg))

endmodule
